@@ design/iqnco_pkg.sv @@
// Package for the IQ NCO frequency shifter: widths, constants, sample type
// and the fixed-point rounding and saturation helpers.
// No dependencies.
package iqnco_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int TMP_WIDTH    = SAMPLE_WIDTH + 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic REG_ROT_COS = 1'b0;
	localparam logic REG_ROT_SIN = 1'b1;

	// Q2.30 constants
	localparam logic signed [31:0] ONE_Q30       = 32'sd1073741824;
	localparam logic signed [39:0] GAIN_BIAS_Q30 = 40'sd2093796557;
	localparam logic signed [31:0] MIX_SCALE_Q30 = 32'sd1181116006;
	localparam logic signed [63:0] HALF_LSB      = 64'sd536870912;

	localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
	localparam logic signed [39:0] S32_MIN = -40'sd2147483648;
	localparam logic signed [39:0] SMP_MAX = 40'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [39:0] SMP_MIN = -SMP_MAX - 40'sd1;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] si;
		logic signed [SAMPLE_WIDTH-1:0] sq;
	} sample_t;

	// round half up, dropping 30 fraction bits (floor shift)
	function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p + HALF_LSB;
		return s[63:30];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		if (x > S32_MAX)
			return 32'sh7fffffff;
		else if (x < S32_MIN)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(input logic signed [39:0] x);
		if (x > SMP_MAX)
			return SMP_MAX[SAMPLE_WIDTH-1:0];
		else if (x < SMP_MIN)
			return SMP_MIN[SAMPLE_WIDTH-1:0];
		else
			return x[SAMPLE_WIDTH-1:0];
	endfunction

endpackage

@@ design/iqnco_if.sv @@
// Valid/ready channel interfaces for the input samples and the shifted results.
// Depends on iqnco_pkg.
interface iqnco_in_if;
	import iqnco_pkg::*;
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_i;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	modport source (output valid, output sample_i, output sample_q, input ready);
	modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface iqnco_out_if;
	import iqnco_pkg::*;
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_i;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	modport source (output valid, output out_i, output out_q, input ready);
	modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

@@ design/iqnco_front.sv @@
// Front end: accepts input transactions into a short sample queue.
// Depends on iqnco_pkg and iqnco_in_if.
module iqnco_front (
	input  logic                clk,
	input  logic                arst_n,
	iqnco_in_if.sink            in_ch,
	output logic                q_valid,
	output iqnco_pkg::sample_t  q_item,
	input  logic                q_pop
);
	import iqnco_pkg::*;

	sample_t                 mem [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0]   wr_ptr_q;
	logic [QPTR_WIDTH-1:0]   rd_ptr_q;
	logic [QCNT_WIDTH-1:0]   cnt_q;
	logic                    push;
	logic                    pop;

	assign in_ch.ready = (cnt_q != QCNT_WIDTH'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_item      = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= '{si: in_ch.sample_i, sq: in_ch.sample_q};
	end

endmodule

@@ design/iqnco_back.sv @@
// Back end: 16-step sequencer around one shared 32x32 multiplier that rotates
// the oscillator, renormalizes it, mixes the sample and holds the result register.
// Depends on iqnco_pkg and iqnco_out_if.
module iqnco_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  iqnco_pkg::sample_t  q_item,
	output logic                q_pop,
	input  logic signed [31:0]  rot_cos,
	input  logic signed [31:0]  rot_sin,
	iqnco_out_if.source         out_ch
);
	import iqnco_pkg::*;

	typedef enum logic {IDLE, RUN} state_t;
	typedef enum logic [3:0] {
		S_VQC, S_VIS, S_VIC, S_VQS, S_VQQ, S_VII, S_GAIN, S_NQ,
		S_NI, S_MA1, S_MA2, S_MB1, S_MB2, S_SCA, S_SCB, S_DONE
	} step_t;

	state_t                         state_q;
	step_t                          step_q;
	logic signed [31:0]             vi_q, vq_q;
	logic signed [SAMPLE_WIDTH-1:0] si_q, sq_q;
	logic signed [63:0]             p_q;
	logic signed [33:0]             ra_q;
	logic signed [31:0]             oq_q, oi_q, gain_q;
	logic signed [63:0]             acc_q;
	logic signed [TMP_WIDTH-1:0]    ta_q, tb_q;
	logic signed [SAMPLE_WIDTH-1:0] yi_q;
	logic                           ov_q;
	logic signed [SAMPLE_WIDTH-1:0] out_i_q, out_q_q;
	logic signed [31:0]             mul_a, mul_b;
	logic signed [33:0]             rp;
	logic                           run, ld_out;

	assign run    = (state_q == RUN);
	assign ld_out = run && (step_q == S_DONE) && (!ov_q || out_ch.ready);
	assign q_pop  = q_valid && (state_q == IDLE || ld_out);
	assign rp     = rnd30(p_q);

	assign out_ch.valid = ov_q;
	assign out_ch.out_i = out_i_q;
	assign out_ch.out_q = out_q_q;

	// multiplier operand select
	always_comb begin
		unique case (step_q)
			S_VQC:  begin mul_a = vq_q;        mul_b = rot_cos;       end
			S_VIS:  begin mul_a = vi_q;        mul_b = rot_sin;       end
			S_VIC:  begin mul_a = vi_q;        mul_b = rot_cos;       end
			S_VQS:  begin mul_a = vq_q;        mul_b = rot_sin;       end
			S_VQQ:  begin mul_a = vq_q;        mul_b = vq_q;          end
			S_VII:  begin mul_a = vi_q;        mul_b = vi_q;          end
			S_NQ:   begin mul_a = gain_q;      mul_b = oq_q;          end
			S_NI:   begin mul_a = gain_q;      mul_b = oi_q;          end
			S_MA1:  begin mul_a = 32'(si_q);   mul_b = oq_q;          end
			S_MA2:  begin mul_a = 32'(sq_q);   mul_b = oi_q;          end
			S_MB1:  begin mul_a = 32'(sq_q);   mul_b = oq_q;          end
			S_MB2:  begin mul_a = 32'(si_q);   mul_b = oi_q;          end
			S_SCA:  begin mul_a = 32'(ta_q);   mul_b = MIX_SCALE_Q30; end
			S_SCB:  begin mul_a = 32'(tb_q);   mul_b = MIX_SCALE_Q30; end
			S_GAIN, S_DONE: begin mul_a = '0;  mul_b = '0;            end
		endcase
	end

	// sequencer, oscillator state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= S_VQC;
			vi_q    <= ONE_Q30;
			vq_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ld_out)
				ov_q <= 1'b1;
			else if (out_ch.ready)
				ov_q <= 1'b0;

			if (q_pop) begin
				state_q <= RUN;
				step_q  <= S_VQC;
			end else if (ld_out) begin
				state_q <= IDLE;
			end else if (run && step_q != S_DONE) begin
				step_q <= step_t'(step_q + 4'd1);
			end

			// renormalized oscillator, product of the previous step
			if (run && step_q == S_NI)
				vq_q <= sat32(40'(rp));
			if (run && step_q == S_MA1)
				vi_q <= sat32(40'(rp));
		end
	end

	// datapath: product register and per-step accumulation
	always_ff @(posedge clk) begin
		// last product is held while the finished result waits for the output
		if (!(run && step_q == S_DONE))
			p_q <= mul_a * mul_b;
		if (q_pop) begin
			si_q <= q_item.si;
			sq_q <= q_item.sq;
		end
		if (ld_out) begin
			out_i_q <= yi_q;
			out_q_q <= sat_smp(40'(rp));
		end
		if (run) begin
			unique case (step_q)
				S_VIS, S_VQS, S_VII: ra_q <= rp;
				S_VIC:  oq_q   <= sat32(40'(ra_q) - 40'(rp));
				S_VQQ:  oi_q   <= sat32(40'(ra_q) + 40'(rp));
				S_GAIN: gain_q <= sat32(GAIN_BIAS_Q30 - (40'(ra_q) + 40'(rp)));
				S_MA2, S_MB2: acc_q <= p_q;
				S_MB1:  ta_q   <= TMP_WIDTH'(rnd30(acc_q + p_q));
				S_SCA:  tb_q   <= TMP_WIDTH'(rnd30(acc_q - p_q));
				S_SCB:  yi_q   <= sat_smp(40'(rp));
				S_VQC, S_NQ, S_NI, S_MA1, S_DONE: ;
			endcase
		end
	end

endmodule

@@ design/iq_nco_frequency_shifter.sv @@
// Top level of the IQ NCO frequency shifter: configuration registers, front
// queue and back-end sequencer. Depends on iqnco_pkg, iqnco_if, iqnco_front, iqnco_back.
// Usage:
//   in_ch carries one complex sample (sample_i, sample_q) per transaction;
//   out_ch returns one shifted pair (out_i, out_q) per input, in order.
//   cfg_we/cfg_index/cfg_wdata write rot_cos (index 0) and rot_sin (index 1),
//   cosine and sine of the per-sample phase step in signed Q2.30.
// Timing:
//   Each sample runs through the back-end step sequence, paced by the single
//   shared 32x32 multiplier doing 14 products in sequence. The back end works
//   on one sample at a time and pops the next as the result loads the output
//   register. An accepted sample passes the queue, the steps and that register
//   before out_ch.valid. A two-entry queue in front takes new samples meanwhile.
// Reset:
//   arst_n clears the queue and the result valid flag, sets the oscillator to
//   (1.0, 0) and the phase step to cos 1.0, sin 0.
// Stall:
//   A result waits in the output register while out_ch.ready is low; the back
//   end still computes the next sample and holds at its last step until the
//   register frees. in_ch.ready drops once the queue is full.
module iq_nco_frequency_shifter (
	input  logic        clk,
	input  logic        arst_n,
	iqnco_in_if.sink    in_ch,
	iqnco_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	import iqnco_pkg::*;

	logic signed [31:0] rot_cos_q, rot_sin_q;
	logic               q_valid, q_pop;
	sample_t            q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_cos_q <= ONE_Q30;
			rot_sin_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROT_COS: rot_cos_q <= cfg_wdata;
				REG_ROT_SIN: rot_sin_q <= cfg_wdata;
			endcase
		end
	end

	iqnco_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	iqnco_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rot_cos (rot_cos_q),
		.rot_sin (rot_sin_q),
		.out_ch  (out_ch)
	);

endmodule
